### rtl/pkd_pkg.sv
// Shared types, widths, register codes and reset values of the plucked string voice.
package pkd_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PERIOD_W   = 11;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned FRAMES_W   = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Default delay line depth.
  localparam int unsigned MAX_PERIOD_DEF = 1024;

  // Fade arithmetic: the magnitude of sample times gain stays below 2^31,
  // and the fade numerator and denominator fit in note_frames / 8.
  localparam int unsigned PROD_W     = 31;
  localparam int unsigned FADE_DEN_W = FRAMES_W - 3;
  localparam int unsigned FMUL_W     = PROD_W + FADE_DEN_W;
  localparam int unsigned FADE_NUM_W = FMUL_W - COEF_W;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 11'd2;
  localparam logic [COEF_W-1:0]   DAMPING_RST = 16'd65306;
  localparam logic [COEF_W-1:0]   GAIN_RST    = 16'd26214;
  localparam logic [FRAMES_W-1:0] FRAMES_RST  = 24'd120000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD      = 2'd0,
    REG_DAMPING     = 2'd1,
    REG_GAIN        = 2'd2,
    REG_NOTE_FRAMES = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_GAIN,
    ST_DAMP,
    ST_UPD,
    ST_FGO,
    ST_FDIV,
    ST_EMIT
  } pkd_state_e;

endpackage

### rtl/pkd_chan_if.sv
// Channel interfaces of the plucked string voice: input items, result items, register writes.
interface pkd_in_if import pkd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] excite_sample;

  modport source (output valid, output op, output excite_sample, input ready);
  modport sink   (input valid, input op, input excite_sample, output ready);
endinterface

interface pkd_out_if import pkd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       last;

  modport source (output valid, output out_sample, output last, input ready);
  modport sink   (input valid, input out_sample, input last, output ready);
endinterface

interface pkd_cfg_if import pkd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pkd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pkd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/pkd_div_cell.sv
// One restoring division step: shifts in one dividend bit and produces one quotient bit.
module pkd_div_cell #(
  parameter int unsigned DivW  = 21,
  parameter int unsigned Steps = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [DivW-1:0]  rem_i,
  input  logic [Steps-1:0] low_i,
  input  logic [Steps-1:0] quo_i,
  input  logic [DivW-1:0]  div_i,
  output logic             vld_o,
  output logic [DivW-1:0]  rem_o,
  output logic [Steps-1:0] low_o,
  output logic [Steps-1:0] quo_o
);

  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            take;
  logic [DivW-1:0] rem_d;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign trial = {rem_i, low_i[Steps-1]};
  assign diff  = trial - {1'b0, div_i};
  assign take  = (trial >= {1'b0, div_i});
  assign rem_d = take ? diff[DivW-1:0] : trial[DivW-1:0];

  // Valid travels with the item along the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  // Partial remainder, remaining dividend bits and quotient so far.
  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    low_o <= {low_i[Steps-2:0], 1'b0};
    quo_o <= {quo_i[Steps-2:0], take};
  end

endmodule

### rtl/pkd_div_chain.sv
// Unsigned divider built as a row of restoring step cells, one quotient bit per cell.
module pkd_div_chain #(
  parameter int unsigned NumW  = 36,
  parameter int unsigned DivW  = 21,
  parameter int unsigned Steps = 26
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NumW-1:0]  dividend_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             done_o,
  output logic [Steps-1:0] quotient_o
);

  logic [DivW-1:0]  div_q;
  logic [DivW-1:0]  div_use;
  logic             vld_w [Steps+1];
  logic [DivW-1:0]  rem_w [Steps+1];
  logic [Steps-1:0] low_w [Steps+1];
  logic [Steps-1:0] quo_w [Steps+1];

  // Hold the divisor for the cells behind the first one.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign div_use = start_i ? divisor_i : div_q;

  // The upper dividend bits form the starting remainder; the caller keeps them
  // below the divisor so the quotient fits in Steps bits.
  assign vld_w[0] = start_i;
  assign rem_w[0] = DivW'(dividend_i[NumW-1:Steps]);
  assign low_w[0] = dividend_i[Steps-1:0];
  assign quo_w[0] = '0;

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    pkd_div_cell #(
      .DivW  (DivW),
      .Steps (Steps)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_w[g]),
      .rem_i  (rem_w[g]),
      .low_i  (low_w[g]),
      .quo_i  (quo_w[g]),
      .div_i  ((g == 0) ? div_use : div_q),
      .vld_o  (vld_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .low_o  (low_w[g+1]),
      .quo_o  (quo_w[g+1])
    );
  end

  assign done_o     = vld_w[Steps];
  assign quotient_o = quo_w[Steps];

endmodule

### rtl/plucked_string_synth_top.sv
// Top level of the plucked string voice: registers, delay line, sequencer and divider.
//
//   channel     direction  payload                      accepted when
//   in_chan_i   in         op, excite_sample            valid && ready
//   out_chan_o  out        out_sample, last             valid && ready
//   cfg_chan_i  in         index, data                  valid (ready is always high)
//
// A load item is handled while idle. A tick runs two delay line reads through
// the single RAM read port, three multiplier stages and the write-back. The first
// tick of a note and every tick in the tail fade add a pass through the divider
// chain of K = 16 + log2(MaxPeriod) cells (26 by default). Reset clears the
// registers and note state; the delay line itself is not cleared. A finished
// result waits in the output register; a load item is still taken then.
module plucked_string_synth_top import pkd_pkg::*; #(
  parameter int unsigned MaxPeriod = MAX_PERIOD_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pkd_in_if.sink     in_chan_i,
  pkd_out_if.source  out_chan_o,
  pkd_cfg_if.sink    cfg_chan_i
);

  localparam int unsigned IW  = $clog2(MaxPeriod);
  localparam int unsigned PW  = ($clog2(MaxPeriod + 1) > PERIOD_W) ?
                                $clog2(MaxPeriod + 1) : PERIOD_W;
  localparam int unsigned SW  = SAMPLE_W + IW;
  localparam int unsigned DNW = (FADE_NUM_W > SW) ? FADE_NUM_W : SW;
  localparam int unsigned DDW = (FADE_DEN_W > PW) ? FADE_DEN_W : PW;
  localparam int unsigned DK  = SW;

  // Subtract with saturation to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sub_sat(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] d;
    d = SAMPLE_W'(0);
    d = (SAMPLE_W+1)'(a) - (SAMPLE_W+1)'(b);
    if (d[SAMPLE_W] != d[SAMPLE_W-1]) begin
      sub_sat = d[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sub_sat = d[SAMPLE_W-1:0];
    end
  endfunction

  // Configuration registers.
  logic [PERIOD_W-1:0] period_q;
  logic [COEF_W-1:0]   damping_q;
  logic [COEF_W-1:0]   gain_q;
  logic [FRAMES_W-1:0] frames_q;

  // Note state.
  logic [IW-1:0]              line_idx_q;
  logic [PW-1:0]              load_cnt_q;
  logic signed [SW-1:0]       exc_sum_q;
  logic signed [SAMPLE_W-1:0] dc_mean_q;
  logic                       first_pass_q;
  logic [FRAMES_W-1:0]        frame_cnt_q;

  // Sequencer and per-tick working registers.
  pkd_state_e                 state_q, state_d;
  logic [IW-1:0]              idx_q, nxt_q;
  logic signed [SAMPLE_W-1:0] cur_q, nv_q;
  logic [PROD_W-1:0]          prod_q;
  logic [COEF_W+SAMPLE_W:0]   dprod_q;
  logic [FMUL_W-1:0]          fmul_q;
  logic                       neg_q, dneg_q;
  logic                       last_q;
  logic [SAMPLE_W-1:0]        y_q;

  // Output register.
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_sample_q;
  logic                       out_last_q;

  // Combinational helpers.
  op_e                        in_op;
  logic                       in_acc;
  logic                       in_ready;
  logic                       slot_free;
  logic [PW-1:0]              p_raw, p_eff;
  logic [IW-1:0]              idx_w, nxt_w;
  logic                       load_ok;
  logic                       note_over;
  logic [SW-1:0]              sum_mag;
  logic [FADE_DEN_W-1:0]      fade_den;
  logic [FRAMES_W-1:0]        fade_start;
  logic [FADE_DEN_W-1:0]      fade_num;
  logic                       fade_now;
  logic [FRAMES_W-1:0]        frame_inc;
  logic signed [SAMPLE_W-1:0] adj_w;
  logic [SAMPLE_W-1:0]        cur_mag;
  logic [31:0]                gprod;
  logic signed [SAMPLE_W:0]   sum17;
  logic [SAMPLE_W:0]          dmag;
  logic [COEF_W+SAMPLE_W:0]   dprod;
  logic [SAMPLE_W-1:0]        nmag;
  logic [SAMPLE_W-1:0]        new_entry;
  logic [SAMPLE_W-1:0]        ymag;
  logic [SAMPLE_W-1:0]        y_plain;
  logic [SAMPLE_W-1:0]        dc_sat;

  // RAM and divider ports.
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0]        ram_wdata, ram_rdata;
  logic                       div_start, div_done;
  logic [DNW-1:0]             div_dividend;
  logic [DDW-1:0]             div_divisor;
  logic [DK-1:0]              div_quo;

  // Handshakes.
  assign in_op            = op_e'(in_chan_i.op);
  assign in_chan_i.ready  = in_ready;
  assign in_acc           = in_chan_i.valid && in_ready;
  assign cfg_chan_i.ready = 1'b1;
  assign slot_free        = !out_valid_q || out_chan_o.ready;

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.out_sample = out_sample_q;
  assign out_chan_o.last       = out_last_q;

  // Period clamped to between 2 and the delay line depth.
  assign p_raw = PW'(period_q);
  always_comb begin
    p_eff = p_raw;
    if (p_raw < PW'(2)) begin
      p_eff = PW'(2);
    end else if (p_raw > PW'(MaxPeriod)) begin
      p_eff = PW'(MaxPeriod);
    end
  end

  // Read position and its neighbor, wrapping at the period.
  assign idx_w = (PW'(line_idx_q) < p_eff) ? line_idx_q : '0;
  assign nxt_w = ((PW'(idx_w) + PW'(1)) == p_eff) ? '0 : IW'(idx_w + IW'(1));

  assign load_ok   = first_pass_q && (frame_cnt_q == '0) && (load_cnt_q < p_eff);
  assign note_over = (frame_cnt_q >= frames_q);
  assign sum_mag   = exc_sum_q[SW-1] ? SW'(-exc_sum_q) : SW'(exc_sum_q);

  // Tail fade over the last eighth of the note.
  assign fade_den   = frames_q[FRAMES_W-1:3];
  assign fade_start = frames_q - FRAMES_W'(fade_den);
  assign fade_num   = FADE_DEN_W'(frames_q - frame_cnt_q);
  assign fade_now   = (fade_den != '0) && (frame_cnt_q >= fade_start);
  assign frame_inc  = FRAMES_W'(frame_cnt_q + FRAMES_W'(1));

  // Entry with the DC mean taken off on its first read.
  assign adj_w = sub_sat(ram_rdata, dc_mean_q);

  // Gain product on the magnitude.
  assign cur_mag = cur_q[SAMPLE_W-1] ? SAMPLE_W'(16'd0 - cur_q) : SAMPLE_W'(cur_q);
  assign gprod   = 32'(cur_mag) * 32'(gain_q);

  // Damped average of the entry and its neighbor.
  assign sum17 = (SAMPLE_W+1)'(cur_q) + (SAMPLE_W+1)'(nv_q);
  assign dmag  = sum17[SAMPLE_W] ? (SAMPLE_W+1)'(-sum17) : (SAMPLE_W+1)'(sum17);
  assign dprod = (COEF_W+SAMPLE_W+1)'(dmag) * (COEF_W+SAMPLE_W+1)'(damping_q);

  assign nmag      = dprod_q[COEF_W+SAMPLE_W:COEF_W+1];
  assign new_entry = dneg_q ? SAMPLE_W'(16'd0 - nmag) : nmag;

  // Output outside the fade is the gain product shifted down.
  assign ymag    = {1'b0, prod_q[PROD_W-1:COEF_W]};
  assign y_plain = neg_q ? SAMPLE_W'(16'd0 - ymag) : ymag;

  // DC mean from the divider quotient, saturated.
  always_comb begin
    if (!neg_q) begin
      dc_sat = (div_quo > DK'(32767)) ? 16'h7FFF : div_quo[SAMPLE_W-1:0];
    end else begin
      dc_sat = (div_quo > DK'(32768)) ? 16'h8000 :
               SAMPLE_W'(16'd0 - div_quo[SAMPLE_W-1:0]);
    end
  end

  // Sequencer: next state and control outputs.
  always_comb begin
    state_d      = state_q;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = new_entry;
    ram_raddr    = idx_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (in_op == OP_LOAD) begin
            ram_we    = load_ok;
            ram_waddr = load_cnt_q[IW-1:0];
            ram_wdata = in_chan_i.excite_sample;
          end else if (note_over) begin
            state_d = ST_EMIT;
          end else if (frame_cnt_q == '0) begin
            div_start    = 1'b1;
            div_dividend = DNW'(sum_mag);
            div_divisor  = DDW'(p_eff);
            state_d      = ST_DC;
          end else begin
            state_d = ST_RD0;
          end
        end
      end
      ST_DC: begin
        if (div_done) begin
          state_d = ST_RD0;
        end
      end
      ST_RD0: begin
        ram_raddr = idx_q;
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        ram_raddr = nxt_q;
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        state_d = ST_DAMP;
      end
      ST_DAMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = new_entry;
        state_d   = fade_now ? ST_FGO : ST_EMIT;
      end
      ST_FGO: begin
        div_start    = 1'b1;
        div_dividend = DNW'(fmul_q[FMUL_W-1:COEF_W]);
        div_divisor  = DDW'(fade_den);
        state_d      = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      damping_q <= DAMPING_RST;
      gain_q    <= GAIN_RST;
      frames_q  <= FRAMES_RST;
    end else if (cfg_chan_i.valid) begin
      case (cfg_reg_e'(cfg_chan_i.index))
        REG_PERIOD:      period_q  <= cfg_chan_i.data[PERIOD_W-1:0];
        REG_DAMPING:     damping_q <= cfg_chan_i.data[COEF_W-1:0];
        REG_GAIN:        gain_q    <= cfg_chan_i.data[COEF_W-1:0];
        REG_NOTE_FRAMES: frames_q  <= cfg_chan_i.data[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // Note state: excitation loads, DC mean and per-tick advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_idx_q   <= '0;
      load_cnt_q   <= '0;
      exc_sum_q    <= '0;
      dc_mean_q    <= '0;
      first_pass_q <= 1'b1;
      frame_cnt_q  <= '0;
    end else begin
      if (state_q == ST_IDLE && in_acc && in_op == OP_LOAD && load_ok) begin
        exc_sum_q  <= SW'(exc_sum_q + SW'(in_chan_i.excite_sample));
        load_cnt_q <= PW'(load_cnt_q + PW'(1));
      end
      if (state_q == ST_DC && div_done) begin
        dc_mean_q <= dc_sat;
      end
      if (state_q == ST_UPD) begin
        line_idx_q  <= nxt_q;
        frame_cnt_q <= frame_inc;
        if (nxt_q == '0) begin
          first_pass_q <= 1'b0;
        end
      end
    end
  end

  // Per-tick working registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_TICK) begin
          idx_q  <= idx_w;
          nxt_q  <= nxt_w;
          neg_q  <= exc_sum_q[SW-1];
          y_q    <= '0;
          last_q <= 1'b0;
        end
      end
      ST_RD1: begin
        cur_q <= first_pass_q ? adj_w : ram_rdata;
      end
      ST_RD2: begin
        nv_q <= (first_pass_q && nxt_q != '0) ? adj_w : ram_rdata;
      end
      ST_GAIN: begin
        prod_q <= gprod[PROD_W-1:0];
        neg_q  <= cur_q[SAMPLE_W-1];
      end
      ST_DAMP: begin
        dprod_q <= dprod;
        dneg_q  <= sum17[SAMPLE_W];
      end
      ST_UPD: begin
        fmul_q <= FMUL_W'(prod_q) * FMUL_W'(fade_num);
        last_q <= (frame_inc == frames_q);
        y_q    <= y_plain;
      end
      ST_FDIV: begin
        if (div_done) begin
          y_q <= neg_q ? SAMPLE_W'(16'd0 - div_quo[SAMPLE_W-1:0]) : div_quo[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && slot_free) begin
      out_sample_q <= y_q;
      out_last_q   <= last_q;
    end
  end

  pkd_ram #(
    .Width (SAMPLE_W),
    .Depth (MaxPeriod)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pkd_div_chain #(
    .NumW  (DNW),
    .DivW  (DDW),
    .Steps (DK)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule
